// ===== hdl/dffir_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dffir_pkg
// Shared constants, function codes and controller/datapath link types for
// the direct-form FIR filter.
// ----------------------------------------------------------------------------
package dffir_pkg;

	localparam int MAX_TAPS     = 4096;
	localparam int SAMPLE_WIDTH = 32;

	localparam int ADDR_W  = $clog2(MAX_TAPS);
	localparam int TAPS_W  = $clog2(MAX_TAPS + 1);
	localparam int CFG_W   = 13;
	localparam int FUNC_W  = 2;
	localparam int INDEX_W = 12;
	localparam int COEF_W  = 32;
	localparam int FIELD_W = 32;
	localparam int OUT_W   = 32;
	localparam int PROD_W  = SAMPLE_WIDTH + COEF_W;
	localparam int ACC_W   = PROD_W + ADDR_W + 1;
	localparam int SHIFT   = SAMPLE_WIDTH - 2;

	localparam logic [FUNC_W-1:0] FN_COEF    = 2'd0;
	localparam logic [FUNC_W-1:0] FN_SAMPLE  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_RESTART = 2'd2;

	typedef struct packed {
		logic take_coef;
		logic take_sample;
		logic take_restart;
		logic issue;
		logic rnd;
		logic load;
	} dffir_cmd_t;

	typedef struct packed {
		logic warm;
		logic last_tap;
		logic pipe_empty;
		logic out_free;
	} dffir_sts_t;

endpackage
`default_nettype wire

// ===== hdl/dffir_item_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dffir_item_if
// Input channel: valid/ready handshake carrying one filter request beat.
// ----------------------------------------------------------------------------
interface dffir_item_if import dffir_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [FUNC_W-1:0]         func;
	logic [INDEX_W-1:0]        tap_index;
	logic signed [COEF_W-1:0]  coef_value;
	logic signed [FIELD_W-1:0] sample_value;

	modport source (output valid, func, tap_index, coef_value, sample_value, input ready);
	modport sink   (input valid, func, tap_index, coef_value, sample_value, output ready);
endinterface
`default_nettype wire

// ===== hdl/dffir_result_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dffir_result_if
// Output channel: valid/ready handshake carrying one filter result beat.
// ----------------------------------------------------------------------------
interface dffir_result_if import dffir_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] filtered_value;
	logic                    warming_up;

	modport source (output valid, filtered_value, warming_up, input ready);
	modport sink   (input valid, filtered_value, warming_up, output ready);
endinterface
`default_nettype wire

// ===== hdl/dffir_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dffir_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module dffir_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== hdl/dffir_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dffir_ctrl
// Sequencer: takes request beats, steps the multiply-accumulate sweep and
// hands the finished result to the output register.
// ----------------------------------------------------------------------------
module dffir_ctrl import dffir_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	input  wire logic [FUNC_W-1:0] func,
	output logic                   item_ready,
	output dffir_cmd_t             cmd,
	input  wire dffir_sts_t        sts
);
	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_MAC    = 5'b00010,
		S_DRAIN  = 5'b00100,
		S_ROUND  = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;

	always_comb begin
		cmd              = '0;
		cmd.take_coef    = accept && (func == FN_COEF);
		cmd.take_sample  = accept && (func == FN_SAMPLE);
		cmd.take_restart = accept && (func == FN_RESTART);
		cmd.issue        = (state_q == S_MAC);
		cmd.rnd          = (state_q == S_ROUND);
		cmd.load         = (state_q == S_FINISH) && sts.out_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				// warm-up beats skip the sweep and report zero
				if (cmd.take_sample) begin
					state_d = sts.warm ? S_FINISH : S_MAC;
				end
			end
			S_MAC: begin
				if (sts.last_tap) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (sts.pipe_empty) begin
					state_d = S_ROUND;
				end
			end
			S_ROUND: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/dffir_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dffir_dp
// Datapath: tap and history memories, read pointers, one multiplier, the
// wide accumulator, rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module dffir_dp import dffir_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_W-1:0]          cfg_wdata,
	input  wire logic [INDEX_W-1:0]        tap_index,
	input  wire logic signed [COEF_W-1:0]  coef_value,
	input  wire logic signed [FIELD_W-1:0] sample_value,
	input  wire dffir_cmd_t                cmd,
	output dffir_sts_t                     sts,
	output logic                           res_valid,
	input  wire logic                      res_ready,
	output logic signed [OUT_W-1:0]        res_value,
	output logic                           res_warm
);
	localparam logic [ACC_W-1:0] HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (SAMPLE_WIDTH - 3);
	localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
	localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};

	logic [TAPS_W-1:0]       taps_q;
	logic [TAPS_W-1:0]       seen_q;
	logic [TAPS_W-1:0]       seen_next;
	logic [ADDR_W-1:0]       wp_q;
	logic [ADDR_W-1:0]       rd_ptr_q;
	logic [ADDR_W-1:0]       m_q;
	logic                    warm_q;
	logic                    rd_v_s1;
	logic                    prod_v_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] rnd_q;
	logic signed [ACC_W-1:0] shifted;
	logic [ACC_W-OUT_W:0]    upper;
	logic [OUT_W-1:0]        sat_val;
	logic                    coef_we;
	logic [COEF_W-1:0]       coef_rd;
	logic [SAMPLE_WIDTH-1:0] hist_rd;
	logic                    out_v_q;
	logic [OUT_W-1:0]        out_val_q;
	logic                    out_warm_q;

	assign coef_we = cmd.take_coef && (32'(tap_index) < MAX_TAPS);

	dffir_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TAPS)) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (ADDR_W'(tap_index)),
		.wdata ($unsigned(coef_value)),
		.re    (cmd.issue),
		.raddr (m_q),
		.rdata (coef_rd)
	);

	dffir_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(MAX_TAPS)) u_hist_ram (
		.clk   (clk),
		.we    (cmd.take_sample),
		.waddr (wp_q),
		.wdata (SAMPLE_WIDTH'($unsigned(sample_value))),
		.re    (cmd.issue),
		.raddr (rd_ptr_q),
		.rdata (hist_rd)
	);

	assign seen_next = (seen_q == TAPS_W'(MAX_TAPS)) ? seen_q : seen_q + 1'b1;

	always_comb begin
		sts.warm       = seen_next < taps_q;
		sts.last_tap   = (m_q == ADDR_W'(taps_q - 1'b1));
		sts.pipe_empty = !rd_v_s1 && !prod_v_s2;
		sts.out_free   = !out_v_q || res_ready;
	end

	// control state: tap count, series position and sweep counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q    <= TAPS_W'(1);
			seen_q    <= '0;
			wp_q      <= '0;
			rd_ptr_q  <= '0;
			m_q       <= '0;
			rd_v_s1   <= 1'b0;
			prod_v_s2 <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				priority if (cfg_wdata == '0) begin
					taps_q <= TAPS_W'(1);
				end else if (32'(cfg_wdata) > MAX_TAPS) begin
					taps_q <= TAPS_W'(MAX_TAPS);
				end else begin
					taps_q <= TAPS_W'(cfg_wdata);
				end
			end
			if (cmd.take_restart) begin
				seen_q <= '0;
				wp_q   <= '0;
			end else if (cmd.take_sample) begin
				seen_q   <= seen_next;
				wp_q     <= (wp_q == ADDR_W'(MAX_TAPS - 1)) ? '0 : wp_q + 1'b1;
				rd_ptr_q <= wp_q;
				m_q      <= '0;
			end else if (cmd.issue) begin
				// walk the history backwards, wrapping at the bottom
				m_q      <= m_q + 1'b1;
				rd_ptr_q <= (rd_ptr_q == '0) ? ADDR_W'(MAX_TAPS - 1) : rd_ptr_q - 1'b1;
			end
			rd_v_s1   <= cmd.issue;
			prod_v_s2 <= rd_v_s1;
			if (cmd.load) begin
				out_v_q <= 1'b1;
			end else if (res_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_sample) begin
			warm_q <= sts.warm;
		end
		if (rd_v_s1) begin
			prod_s2 <= $signed(hist_rd) * $signed(coef_rd);
		end
		if (cmd.take_sample) begin
			acc_q <= '0;
		end else if (prod_v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (cmd.rnd) begin
			rnd_q <= acc_q + $signed(HALF);
		end
		if (cmd.load) begin
			out_val_q  <= warm_q ? '0 : sat_val;
			out_warm_q <= warm_q;
		end
	end

	// drop the fraction bits, then clamp to the output range
	always_comb begin
		shifted = rnd_q >>> SHIFT;
		upper   = shifted[ACC_W-1:OUT_W-1];
		priority if ((&upper) || !(|upper)) begin
			sat_val = shifted[OUT_W-1:0];
		end else if (upper[ACC_W-OUT_W]) begin
			sat_val = SAT_MIN;
		end else begin
			sat_val = SAT_MAX;
		end
	end

	assign res_valid = out_v_q;
	assign res_value = $signed(out_val_q);
	assign res_warm  = out_warm_q;
endmodule
`default_nettype wire

// ===== hdl/direct_form_fir_filter.sv =====
`default_nettype none
// Coefficient and restart beats are taken in the idle state. A warm-up sample
// skips the sweep; a full sample sweeps, drains, rounds and loads. No request
// is taken until the result is loaded. The sweep does one multiply-accumulate
// per cycle through the single read port of each tap and history memory.
// Reset clears the controller, pointers, sample count and output valid and
// sets the tap count to 1; memory contents stay undefined until written.
// ----------------------------------------------------------------------------
// direct_form_fir_filter
// Direct-form FIR filter with loadable taps, rounding and saturation.
// ----------------------------------------------------------------------------
module direct_form_fir_filter import dffir_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	dffir_item_if.sink      item,
	dffir_result_if.source  result,
	input  wire logic       cfg_we,
	input  wire logic [CFG_W-1:0] cfg_wdata
);
	dffir_cmd_t cmd;
	dffir_sts_t sts;

	dffir_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.func       (item.func),
		.item_ready (item.ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	dffir_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.tap_index    (item.tap_index),
		.coef_value   (item.coef_value),
		.sample_value (item.sample_value),
		.cmd          (cmd),
		.sts          (sts),
		.res_valid    (result.valid),
		.res_ready    (result.ready),
		.res_value    (result.filtered_value),
		.res_warm     (result.warming_up)
	);

	// a sample beat holds off the next request while it is worked
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready && item.func == FN_SAMPLE |=> !item.ready)
		else $error("request taken while a sample was in progress");

	// write and restart beats never raise a result
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready && item.func != FN_SAMPLE && !result.valid
		|=> !result.valid)
		else $error("result raised by a beat that carries none");

	// warm-up results carry zero
	a_warm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.warming_up |-> result.filtered_value == '0)
		else $error("warm-up result not zero");

	// the sweep never runs while a request is being taken
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> !item.ready)
		else $error("request port open during the sweep");
endmodule
`default_nettype wire

// ===== bench/tb_direct_form_fir_filter.sv =====
// ----------------------------------------------------------------------------
// tb_direct_form_fir_filter
// Self-checking bench for the direct-form FIR filter. A clocked driver feeds
// coefficient, sample and restart beats from a queue; a clocked monitor
// tracks tap memory, sample history and warm-up count in its own fixed-point
// model and checks every output beat in order. Tap counts run from 0 to the
// register maximum, and the idle patterns on both channels change by phase.
// ----------------------------------------------------------------------------
module tb_direct_form_fir_filter;
	import dffir_pkg::*;

	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned LONG_STALL_CYCLES = 400;
	localparam int unsigned END_WAIT_CYCLES = 20000;
	localparam int unsigned TIMEOUT_UNITS = 2000000;
	localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (SHIFT - 1);
	localparam logic signed [127:0] ACC_MAX = 128'sd2147483647;
	localparam logic signed [127:0] ACC_MIN = -128'sd2147483648;

	typedef struct packed {
		logic [FUNC_W-1:0]         func;
		logic [INDEX_W-1:0]        tap_index;
		logic signed [COEF_W-1:0]  coef_value;
		logic signed [FIELD_W-1:0] sample_value;
	} fir_beat_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] filtered_value;
		logic                    warming_up;
	} fir_output_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	dffir_item_if   item_ch ();
	dffir_result_if result_ch ();

	direct_form_fir_filter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// filter model state
	logic signed [COEF_W-1:0]       coef_mem [MAX_TAPS];
	logic signed [SAMPLE_WIDTH-1:0] hist_mem [MAX_TAPS];
	int unsigned      hist_wr = 0;
	int unsigned      hist_seen = 0;
	logic [CFG_W-1:0] taps_reg = CFG_W'(1);

	fir_beat_t   pending_beats [$];
	fir_output_t pending_outputs [$];
	fir_beat_t   drive_beat;
	bit          coef_loaded [MAX_TAPS];

	int unsigned items_queued = 0;
	int unsigned items_accepted = 0;
	int unsigned outputs_checked = 0;
	int unsigned warm_outputs = 0;
	int unsigned saturated_outputs = 0;
	int unsigned mismatches = 0;
	int unsigned gen_taps = 1;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	bit          long_stall_on = 1'b0;
	int unsigned long_stall_cnt = 0;
	logic        in_beat = 1'b0;

	function automatic void fir_apply_beat(fir_beat_t b);
		fir_output_t want;
		logic signed [127:0] acc;
		int unsigned taps, cur, idx, m;
		case (b.func)
			FN_COEF: begin
				coef_mem[b.tap_index] = b.coef_value;
			end
			FN_RESTART: begin
				hist_wr = 0;
				hist_seen = 0;
			end
			FN_SAMPLE: begin
				taps = (taps_reg == 0) ? 1 : ((taps_reg > MAX_TAPS) ? MAX_TAPS : taps_reg);
				cur = hist_wr;
				hist_mem[cur] = b.sample_value[SAMPLE_WIDTH-1:0];
				hist_wr = (cur + 1 == MAX_TAPS) ? 0 : cur + 1;
				if (hist_seen < MAX_TAPS)
					hist_seen++;
				want.warming_up = (hist_seen < taps);
				want.filtered_value = '0;
				if (want.warming_up) begin
					warm_outputs++;
				end else begin
					acc = '0;
					for (m = 0; m < taps; m++) begin
						idx = (cur + MAX_TAPS - m) % MAX_TAPS;
						acc = acc + hist_mem[idx] * coef_mem[m];
					end
					acc = (acc + ROUND_HALF) >>> SHIFT;
					// clamp to Q1.31
					if (acc > ACC_MAX) begin
						acc = ACC_MAX;
						saturated_outputs++;
					end else if (acc < ACC_MIN) begin
						acc = ACC_MIN;
						saturated_outputs++;
					end
					want.filtered_value = acc[OUT_W-1:0];
				end
				pending_outputs.push_back(want);
			end
			default: ;
		endcase
	endfunction

	task automatic log_mismatch(string what, fir_output_t want, fir_output_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected value %0d warm %0b, got value %0d warm %0b", $time,
				what, want.filtered_value, want.warming_up, got.filtered_value, got.warming_up);
	endtask

	// input side: track config writes and accepted beats
	always @(posedge clk) begin
		in_beat <= item_ch.valid && item_ch.ready;
		if (arst_n) begin
			if (cfg_we)
				taps_reg = cfg_wdata;
			if (item_ch.valid && item_ch.ready) begin
				items_accepted++;
				fir_apply_beat('{item_ch.func, item_ch.tap_index, item_ch.coef_value,
					item_ch.sample_value});
			end
		end
	end

	// output side: check each beat against the oldest pending output
	always @(posedge clk) begin
		fir_output_t got, want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.filtered_value = result_ch.filtered_value;
			got.warming_up = result_ch.warming_up;
			if (pending_outputs.size() == 0) begin
				log_mismatch("output with nothing pending", '0, got);
			end else begin
				want = pending_outputs.pop_front();
				outputs_checked++;
				if (got !== want)
					log_mismatch("output mismatch", want, got);
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!item_ch.valid || in_beat)) begin
			if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drive_beat = pending_beats.pop_front();
				item_ch.valid <= 1'b1;
				item_ch.func <= drive_beat.func;
				item_ch.tap_index <= drive_beat.tap_index;
				item_ch.coef_value <= drive_beat.coef_value;
				item_ch.sample_value <= drive_beat.sample_value;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (long_stall_on && long_stall_cnt < LONG_STALL_CYCLES) begin
			long_stall_cnt <= long_stall_cnt + 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic logic [31:0] pick_word(int unsigned quiet);
		logic signed [31:0] w;
		w = $urandom;
		if (quiet != 0)
			return w >>> (quiet + $urandom_range(3));
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			3, 4, 5: return w;
			default: return w >>> $urandom_range(1, 16);
		endcase
	endfunction

	function automatic void queue_beat(logic [FUNC_W-1:0] f, int unsigned slot,
			logic [31:0] cv, logic [31:0] sv);
		fir_beat_t b;
		b.func = f;
		b.tap_index = INDEX_W'(slot);
		b.coef_value = cv;
		b.sample_value = sv;
		if (f == FN_COEF)
			coef_loaded[slot] = 1'b1;
		pending_beats.push_back(b);
		items_queued++;
	endfunction

	function automatic void write_coef(int unsigned slot, logic [31:0] v);
		queue_beat(FN_COEF, slot, v, $urandom);
	endfunction

	function automatic void send_sample(logic [31:0] v);
		queue_beat(FN_SAMPLE, $urandom_range(MAX_TAPS - 1), $urandom, v);
	endfunction

	function automatic void send_restart();
		queue_beat(FN_RESTART, $urandom_range(MAX_TAPS - 1), $urandom, $urandom);
	endfunction

	// wait until every beat is taken and every output has come, then settle
	task automatic drain();
		while (items_accepted != items_queued || pending_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_taps(int unsigned v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= CFG_W'(v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// idle, set the tap count, load each unloaded coefficient the count would read
	task automatic start_phase(int unsigned taps_cfg, bit restart);
		int unsigned s;
		drain();
		program_taps(taps_cfg);
		gen_taps = (taps_cfg == 0) ? 1 : ((taps_cfg > MAX_TAPS) ? MAX_TAPS : taps_cfg);
		for (s = 0; s < gen_taps; s++)
			if (!coef_loaded[s])
				write_coef(s, pick_word(gen_taps > 64 ? 10 : 0));
		if (restart)
			send_restart();
	endtask

	task automatic random_items(int unsigned n);
		int unsigned pick;
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 75)
				send_sample(pick_word(0));
			else if (pick < 92)
				write_coef($urandom_range(1) ? $urandom_range(gen_taps - 1)
					: $urandom_range(MAX_TAPS - 1), pick_word(0));
			else if (pick < 95)
				send_restart();
			else
				queue_beat(FN_UNUSED, $urandom_range(MAX_TAPS - 1), $urandom, $urandom);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.func = '0;
		item_ch.tap_index = '0;
		item_ch.coef_value = '0;
		item_ch.sample_value = '0;
		result_ch.ready = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 6;
		recv_idle_pct = 82;

		// single tap after reset: saturation both ways, exact extremes, rounding
		write_coef(0, 32'h8000_0000);
		send_sample(32'h8000_0000);
		send_sample(32'h7FFF_FFFF);
		write_coef(0, 32'h4000_0000);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		write_coef(0, 32'h0000_0001);
		send_sample(32'h2000_0000);
		send_sample(32'hE000_0000);
		queue_beat(FN_UNUSED, $urandom_range(MAX_TAPS - 1), $urandom, $urandom);
		write_coef(MAX_TAPS - 1, 32'h7FFF_FFFF);
		send_sample(32'h0000_0000);

		// two taps: warm-up after restart, cancellation, negative saturation
		start_phase(2, 1'b1);
		write_coef(1, 32'hC000_0000);
		write_coef(0, 32'h4000_0000);
		send_sample(32'h4000_0000);
		send_sample(32'h4000_0000);
		send_sample(32'h8000_0000);
		send_restart();
		send_sample(32'h7FFF_FFFF);

		// tap count of zero behaves as one
		start_phase(0, 1'b0);
		send_sample(32'h1000_0000);

		start_phase(3, 1'b1);
		random_items(8);
		start_phase(5, 1'b0);
		random_items(8);

		send_idle_pct = 82;
		recv_idle_pct = 6;
		start_phase(1, 1'b0);
		random_items(8);
		start_phase(8, 1'b1);
		random_items(10);
		start_phase(16, 1'b0);
		random_items(16);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		// hold the output off while the sender keeps offering beats
		start_phase(4, 1'b1);
		long_stall_on = 1'b1;
		random_items(20);
		// raise the count mid-series so warm-up resumes
		start_phase(32, 1'b0);
		random_items(20);

		// count beyond the memory size: a fresh series stays in warm-up
		drain();
		program_taps((1 << CFG_W) - 1);
		send_restart();
		repeat (3) send_sample(pick_word(0));

		while (items_accepted != items_queued)
			@(posedge clk);
		for (int c = 0; c < END_WAIT_CYCLES && pending_outputs.size() != 0; c++)
			@(posedge clk);
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		if (pending_outputs.size() != 0) begin
			$display("%0d outputs never arrived", pending_outputs.size());
			mismatches += pending_outputs.size();
		end

		$display("Checked %0d outputs (%0d warm-up, %0d saturated) from %0d input beats.",
			outputs_checked, warm_outputs, saturated_outputs, items_accepted);
		$display("Tap counts 0 to 8191, sender and receiver gaps, one long output hold-off.");
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_UNITS);
		$display("Timed out with %0d beats queued and %0d outputs pending",
			pending_beats.size(), pending_outputs.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/dffir_pkg.sv
hdl/dffir_item_if.sv
hdl/dffir_result_if.sv
hdl/dffir_ram.sv
hdl/dffir_ctrl.sv
hdl/dffir_dp.sv
hdl/direct_form_fir_filter.sv
bench/tb_direct_form_fir_filter.sv
